/* rtl/gcp_pkg.sv */
// ----------------------------------------------------------------------------
// gcp_pkg
// Types and constants shared by the glyph crop-and-pack pipeline.
// ----------------------------------------------------------------------------
package gcp_pkg;

   localparam int ROW_W     = 8;   // pixels per row
   localparam int CELL_ROWS = 8;   // rows per cell
   localparam int KEEP_ROWS = 7;   // most rows a packable glyph can keep
   localparam int BITS_W    = 32;  // packed word width
   localparam int CELL_W    = ROW_W * CELL_ROWS;

   localparam logic [7:0] SPACE_METRICS = 8'h60;  // width 3, height 0, offset 0

   typedef logic [ROW_W-1:0] row_type;

   typedef struct packed {
      row_type row_0;
      row_type row_1;
      row_type row_2;
      row_type row_3;
      row_type row_4;
      row_type row_5;
      row_type row_6;
      row_type row_7;
      logic    space_glyph;
   } req_type;

   typedef struct packed {
      logic [7:0]        glyph_metrics;
      logic [BITS_W-1:0] glyph_bits;
      logic              too_large;
   } rsp_type;

   // Cropped, left-aligned glyph handed to the packer.
   typedef struct packed {
      row_type [KEEP_ROWS-1:0] rows;   // rows[0] is the top kept row
      logic [2:0]              w;
      logic [2:0]              h;
      logic [1:0]              top;
      logic                    empty;
      logic                    space;
      logic                    big;
   } crop_type;

endpackage

/* rtl/gcp_packer.sv */
// ----------------------------------------------------------------------------
// gcp_packer
// Packs cropped rows MSB-first, w bits per row, and forms the result item.
// ----------------------------------------------------------------------------
module gcp_packer import gcp_pkg::*; (
   input  crop_type crop,
   output rsp_type  rsp
);

   always_comb begin
      logic [BITS_W-1:0] bits;
      logic [5:0]        pos;
      bits = '0;
      for (int i = 0; i < KEEP_ROWS; i++) begin
         pos = 6'(i) * {3'b000, crop.w};
         // rows starting at bit 32 or later fall off the word
         if (pos < 6'(BITS_W)) begin
            bits = bits | ({crop.rows[i], (BITS_W-ROW_W)'(0)} >> pos[4:0]);
         end
      end

      rsp.too_large = crop.big;
      if (crop.big) begin
         rsp.glyph_metrics = '0;
         rsp.glyph_bits    = '0;
      end else if (crop.empty) begin
         rsp.glyph_metrics = crop.space ? SPACE_METRICS : 8'h00;
         rsp.glyph_bits    = '0;
      end else begin
         rsp.glyph_metrics = {crop.w, crop.h, crop.top};
         rsp.glyph_bits    = bits;
      end
   end

endmodule

/* rtl/glyph_crop_and_pack.sv */
// ----------------------------------------------------------------------------
// glyph_crop_and_pack
// Crops an 8x8 one-bit glyph cell to its inked box and packs it in 32 bits.
// ----------------------------------------------------------------------------
// Usage:
//   req channel carries one cell per transfer: eight row bytes (bit 7 is the
//   leftmost pixel) and the space flag. rsp channel returns one result per
//   cell: metrics byte {w, h, y}, the packed bits and the too_large flag.
//   Results come back in order, one per cell.
//   Pipeline: three register stages, the first loaded at the req transfer:
//   row scan, column scan and crop, pack into the output register.
//   Throughput: one cell per cycle while rsp_stall is low; each stage holds
//   one cell and moves it on as soon as the next stage is free or moving.
//   Stall: when rsp_stall holds a result, the stages behind it keep filling
//   their bubbles; req_stall rises only once every stage is occupied.
//   Reset (synchronous) drops all cells in flight; no result is produced for
//   them. The datapath has no state between cells.
// ----------------------------------------------------------------------------
module glyph_crop_and_pack import gcp_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   // per-stage flow control: a stage loads when it is empty or draining
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff;
   logic s1_ready, s2_ready, s3_ready;

   assign s3_ready  = !s3_valid_ff || !rsp_stall;
   assign s2_ready  = !s2_valid_ff || s3_ready;
   assign s1_ready  = !s1_valid_ff || s2_ready;
   assign req_stall = !s1_ready;

   // ---------------- stage 1: row scan ----------------
   // y = leading empty rows (max 3), h = rows from y through last inked row.
   logic [CELL_W-1:0] cell_in;
   logic [CELL_ROWS-1:0] nz;
   logic [1:0] top_in;
   logic [3:0] h_in;
   logic [2:0] last;
   row_type    agg_in;
   logic       empty_in;

   assign cell_in = {req_data.row_0, req_data.row_1, req_data.row_2, req_data.row_3,
                     req_data.row_4, req_data.row_5, req_data.row_6, req_data.row_7};

   always_comb begin
      agg_in = '0;
      last   = '0;
      for (int i = 0; i < CELL_ROWS; i++) begin
         nz[i]  = |cell_in[CELL_W-1-ROW_W*i -: ROW_W];
         agg_in = agg_in | cell_in[CELL_W-1-ROW_W*i -: ROW_W];
         if (nz[i]) begin
            last = 3'(i);
         end
      end
      empty_in = !(|nz);

      priority if (nz[0]) top_in = 2'd0;
      else if (nz[1])     top_in = 2'd1;
      else if (nz[2])     top_in = 2'd2;
      else                top_in = 2'd3;

      // when the cell is not empty, the last inked row is at or below y
      h_in = empty_in ? 4'd0 : ({1'b0, last} - {2'b00, top_in} + 4'd1);
   end

   logic [CELL_W-1:0] s1_cell_ff;
   row_type           s1_agg_ff;
   logic [1:0]        s1_top_ff;
   logic [3:0]        s1_h_ff;
   logic              s1_empty_ff, s1_space_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready && req_valid) begin
         s1_cell_ff  <= cell_in;
         s1_agg_ff   <= agg_in;
         s1_top_ff   <= top_in;
         s1_h_ff     <= h_in;
         s1_empty_ff <= empty_in;
         s1_space_ff <= req_data.space_glyph;
      end
   end

   // ---------------- stage 2: column scan and crop ----------------
   // span of inked columns gives w; rows are moved up by y, masked past h,
   // and shifted left so the leftmost inked column sits in bit 7.
   logic [2:0] hi, lo, lead;
   logic [3:0] w4;
   logic [CELL_W-1:0] kept;
   crop_type crop_in;

   always_comb begin
      hi = '0;
      lo = '0;
      for (int i = 0; i < ROW_W; i++) begin
         if (s1_agg_ff[i]) hi = 3'(i);
      end
      for (int i = ROW_W-1; i >= 0; i--) begin
         if (s1_agg_ff[i]) lo = 3'(i);
      end
      w4   = {1'b0, hi} - {1'b0, lo} + 4'd1;
      lead = 3'd7 - hi;
      kept = s1_cell_ff << {s1_top_ff, 3'b000};

      for (int i = 0; i < KEEP_ROWS; i++) begin
         if (4'(i) < s1_h_ff) begin
            crop_in.rows[i] = kept[CELL_W-1-ROW_W*i -: ROW_W] << lead;
         end else begin
            crop_in.rows[i] = '0;
         end
      end
      crop_in.w     = w4[2:0];
      crop_in.h     = s1_h_ff[2:0];
      crop_in.top   = s1_top_ff;
      crop_in.empty = s1_empty_ff;
      crop_in.space = s1_space_ff;
      crop_in.big   = !s1_empty_ff && (w4[3] || s1_h_ff[3]);
   end

   crop_type s2_crop_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_ready) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_ready && s1_valid_ff) begin
         s2_crop_ff <= crop_in;
      end
   end

   // ---------------- stage 3: pack into the output register ----------------
   rsp_type rsp_in;
   rsp_type s3_rsp_ff;

   gcp_packer u_packer (
      .crop (s2_crop_ff),
      .rsp  (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (s3_ready) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s3_ready && s2_valid_ff) begin
         s3_rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = s3_valid_ff;
   assign rsp_data  = s3_rsp_ff;

endmodule

/* rtl/gcp_checker.sv */
// ----------------------------------------------------------------------------
// gcp_checker
// Port-level checks for glyph_crop_and_pack, bound to the top level.
// ----------------------------------------------------------------------------
module gcp_checker import gcp_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_stall,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   // a held result keeps its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("rsp changed while stalled");

   // reset flushes the pipeline
   a_reset_flush: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid after reset");

   // with the output stage empty nothing can back up to the input
   a_no_false_stall: assert property (@(posedge clock)
      !rsp_valid |-> !req_stall)
      else $error("req_stall with empty output stage");

   // an oversized glyph yields zero metrics and bits
   a_too_large_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.too_large |->
         rsp_data.glyph_metrics == 8'h00 && rsp_data.glyph_bits == '0)
      else $error("too_large result carries data");

endmodule

bind glyph_crop_and_pack gcp_checker u_gcp_checker (.*);

/* tb/tb_glyph_crop_and_pack.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_glyph_crop_and_pack
// Self-checking bench for the glyph crop-and-pack pipeline.
// Directed cells hit the corner cases. Random cells then run under four
// idle mixes and one long output hold. A scoreboard predicts every result
// and checks each rsp transfer in order.
// ----------------------------------------------------------------------------
module tb_glyph_crop_and_pack;
   import gcp_pkg::*;

   localparam int TOP_SKIP_MAX = 3;               // empty top rows that may be skipped
   localparam int ALIGN_SHIFT  = BITS_W - ROW_W;  // row byte to the top of the word
   localparam int RANDOM_CELLS = 450;             // per idle mix, four mixes
   localparam int HOLD_CYCLES  = 60;              // long output hold
   localparam int DRAIN_CYCLES = 8;               // pipeline is 3 deep

   // Cropped-box model plus the queue of results still owed by the block.
   class glyph_board;
      rsp_type owed[$];
      int      errors;
      int      n_cells, n_packed, n_empty, n_big, n_checked;

      function rsp_type crop_pack(req_type c);
         row_type     r [CELL_ROWS];
         row_type     ink;
         logic [31:0] aligned;
         int          top, ht, lo, hi, wd, pos, i;
         rsp_type     res;
         r   = '{c.row_0, c.row_1, c.row_2, c.row_3, c.row_4, c.row_5, c.row_6, c.row_7};
         res = '0;
         top = 0;
         ht  = CELL_ROWS;
         while (ht > 0 && top < TOP_SKIP_MAX && r[top] == 0) begin
            top++;
            ht--;
         end
         while (ht > 0 && r[top+ht-1] == 0)
            ht--;
         if (ht == 0) begin
            if (c.space_glyph)
               res.glyph_metrics = SPACE_METRICS;
            return res;
         end
         ink = '0;
         for (i = 0; i < ht; i++)
            ink |= r[top+i];
         lo = 0;
         while (!ink[lo]) lo++;
         hi = ROW_W - 1;
         while (!ink[hi]) hi--;
         wd = hi - lo + 1;
         if (wd > KEEP_ROWS || ht > KEEP_ROWS) begin
            res.too_large = 1'b1;
            return res;
         end
         pos = 0;
         for (i = 0; i < ht; i++) begin
            aligned = {24'b0, r[top+i]} << (ROW_W - 1 - hi + ALIGN_SHIFT);
            if (pos < BITS_W)
               res.glyph_bits |= aligned >> pos;
            pos += wd;
         end
         res.glyph_metrics = {3'(wd), 3'(ht), 2'(top)};
         return res;
      endfunction

      function void note_cell(req_type c);
         rsp_type e;
         e = crop_pack(c);
         owed.push_back(e);
         n_cells++;
         if (e.too_large)
            n_big++;
         else if (e.glyph_bits == 0 && e.glyph_metrics[4:2] == 0)
            n_empty++;
         else
            n_packed++;
      endfunction

      function void check_result(rsp_type got);
         rsp_type e;
         if (owed.size() == 0) begin
            $display("%0t: unexpected result %h", $time, got);
            errors++;
            return;
         end
         e = owed.pop_front();
         n_checked++;
         if (got.glyph_metrics !== e.glyph_metrics) begin
            $display("%0t: glyph_metrics expected %h actual %h",
                     $time, e.glyph_metrics, got.glyph_metrics);
            errors++;
         end
         if (got.glyph_bits !== e.glyph_bits) begin
            $display("%0t: glyph_bits expected %h actual %h",
                     $time, e.glyph_bits, got.glyph_bits);
            errors++;
         end
         if (got.too_large !== e.too_large) begin
            $display("%0t: too_large expected %b actual %b",
                     $time, e.too_large, got.too_large);
            errors++;
         end
      endfunction
   endclass

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   glyph_board board = new;

   // Idle mix of the current phase, in percent.
   int unsigned send_gap_pct;
   int unsigned stall_pct;

   // Long hold requests: the main flow bumps hold_order, the receiver serves it.
   int hold_order;
   int hold_seen;
   int hold_left;

   glyph_crop_and_pack i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Hard stop well past the slowest legal run.
   initial begin
      #400000;
      $display("DONE: errors detected");
      $finish;
   end

   // Receiver: check every rsp transfer, then pick the stall for the next cycle.
   // Values are sampled at the edge before this edge's updates land.
   always @(posedge clock) begin
      if (rsp_valid === 1'b1 && rsp_stall === 1'b0)
         board.check_result(rsp_data);
      if (hold_seen != hold_order) begin
         hold_seen = hold_order;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // Offer one cell; returns at the edge where the transfer happens.
   task automatic send_cell(input req_type glyph);
      while ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         req_data  <= req_type'({$urandom, $urandom, $urandom});
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= glyph;
      @(posedge clock);
      while (req_stall !== 1'b0)
         @(posedge clock);
      board.note_cell(glyph);
   endtask

   function automatic req_type pack_rows(input row_type r [CELL_ROWS], input logic sp);
      return {r[0], r[1], r[2], r[3], r[4], r[5], r[6], r[7], sp};
   endfunction

   // Random cell: mostly glyph-shaped boxes with random ink, some raw noise,
   // some blank cells.
   function automatic req_type random_cell();
      row_type r [CELL_ROWS];
      row_type mask;
      int      mode, wd, lo, first, last, i;
      mode = $urandom_range(9);
      for (i = 0; i < CELL_ROWS; i++)
         r[i] = '0;
      if (mode < 2) begin
         // raw noise, usually oversized
         for (i = 0; i < CELL_ROWS; i++)
            r[i] = $urandom_range(3) == 0 ? row_type'(0) : row_type'($urandom);
      end else if (mode > 2) begin
         wd    = $urandom_range(1, KEEP_ROWS);
         lo    = $urandom_range(0, ROW_W - wd);
         mask  = row_type'(((1 << wd) - 1) << lo);
         first = $urandom_range(0, 4);
         last  = $urandom_range(first, CELL_ROWS - 1);
         for (i = first; i <= last; i++) begin
            if ($urandom_range(4) != 0)
               r[i] = row_type'($urandom) & mask;
         end
         // pin the box edges now and then so the full width shows up
         if ($urandom_range(1)) r[first] |= row_type'(1 << lo);
         if ($urandom_range(1)) r[last]  |= row_type'(1 << (lo + wd - 1));
      end
      return pack_rows(r, 1'(($urandom)));
   endfunction

   task automatic send_rows(input row_type r0, r1, r2, r3, r4, r5, r6, r7,
                            input logic sp);
      send_cell({r0, r1, r2, r3, r4, r5, r6, r7, sp});
   endtask

   int unsigned gap_mix   [4] = '{0, 52, 0, 10};
   int unsigned stall_mix [4] = '{0, 0, 52, 10};

   initial begin
      int ph, n, waited;
      reset        <= 1'b1;
      req_valid    <= 1'b0;
      req_data     <= '0;
      rsp_stall    <= 1'b0;
      send_gap_pct = 0;
      stall_pct    = 0;
      hold_order   = 0;
      hold_seen    = 0;
      hold_left    = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed corners.
      send_rows(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0); // blank
      send_rows(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1); // space
      send_rows(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0); // full
      send_rows(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1);
      send_rows(8'h80, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0); // one pixel
      send_rows(8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1); // top skip 3
      // skip stops at three: row 3 stays as an empty leading row
      send_rows(8'h00, 8'h00, 8'h00, 8'h00, 8'h18, 8'h00, 8'h00, 8'h00, 1'b0);
      send_rows(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 1'b0); // too wide
      send_rows(8'h00, 8'h00, 8'h81, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0); // edge columns
      send_rows(8'h40, 8'h40, 8'h40, 8'h40, 8'h40, 8'h40, 8'h40, 8'h40, 1'b1); // too tall
      // 7x7 boxes: rows past bit 0 are dropped, one row straddles
      send_rows(8'h7F, 8'h7F, 8'h7F, 8'h7F, 8'h7F, 8'h7F, 8'h7F, 8'h00, 1'b0);
      send_rows(8'h00, 8'hFE, 8'hAA, 8'h54, 8'hFE, 8'h82, 8'h44, 8'hFE, 1'b0);
      // 5 wide: last row straddles the word boundary
      send_rows(8'h3E, 8'h22, 8'h3E, 8'h22, 8'h3E, 8'h22, 8'h3E, 8'h00, 1'b0);
      // 6 wide: the last row starts at bit 36 and adds nothing
      send_rows(8'h00, 8'h7E, 8'h42, 8'h42, 8'h7E, 8'h42, 8'h42, 8'h7E, 1'b0);
      // inner blank rows kept, space flag ignored on a non-empty cell
      send_rows(8'h10, 8'h00, 8'h00, 8'h08, 8'h00, 8'h00, 8'h20, 8'h00, 1'b1);
      send_rows(8'h55, 8'h00, 8'h55, 8'h00, 8'h55, 8'h00, 8'h55, 8'h00, 1'b0);
      send_rows(8'h2A, 8'h54, 8'h2A, 8'h54, 8'h2A, 8'h54, 8'h2A, 8'h00, 1'b1);
      send_rows(8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 1'b0); // right edge
      send_rows(8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h00, 1'b0); // left edge
      send_rows(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h02, 1'b1); // bottom only
      send_rows(8'hFE, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 1'b0); // big both

      // Random cells under each idle mix; the first mix also gets the long hold
      // so the pipeline fills and req_stall has to rise.
      for (ph = 0; ph < 4; ph++) begin
         send_gap_pct = gap_mix[ph];
         stall_pct    = stall_mix[ph];
         for (n = 0; n < RANDOM_CELLS; n++) begin
            if (ph == 0 && n == 100)
               hold_order++;
            send_cell(random_cell());
         end
      end
      req_valid <= 1'b0;

      // Drain, then idle for DRAIN_CYCLES to catch stray results.
      waited = 0;
      while (board.owed.size() != 0 && waited < 20000) begin
         @(posedge clock);
         waited++;
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Ran %0d cells (%0d packed, %0d blank, %0d oversized), %0d results checked,",
               board.n_cells, board.n_packed, board.n_empty, board.n_big, board.n_checked);
      $display("under four sender/receiver idle mixes plus one %0d-cycle output hold.",
               HOLD_CYCLES);
      if (board.errors == 0 && board.owed.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

/* sim.f */
rtl/gcp_pkg.sv
rtl/gcp_packer.sv
rtl/glyph_crop_and_pack.sv
rtl/gcp_checker.sv
tb/tb_glyph_crop_and_pack.sv
